// ===== hw/rtl/pbc_pkg.sv =====
// Shared constants, codes and helpers for the boundary-layer cell update.
package pbc_pkg;

  localparam int MAX_LAYERS_DEF = 64;
  localparam int CNT_W = 9;       // holds any layer count up to 511
  localparam int VAL_W = 32;
  localparam int FAC_W = 32;
  localparam int NUM_W = 50;      // dividend width of the factor divider
  localparam int PROD_W = 66;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SINGLE = 2'd1;
  localparam logic [1:0] OP_DOUBLE = 2'd2;

  localparam logic [1:0] SIDE_TOP      = 2'd0;
  localparam logic [1:0] SIDE_BOT_SYM  = 2'd2;
  localparam logic [1:0] SIDE_BOT_ANTI = 2'd3;

  localparam logic [6:0] LAYERS_RST = 7'd32;

  typedef struct packed {
    logic                     act;
    logic                     mir;
    logic                     neg;
    logic                     dbl;
    logic [FAC_W-1:0]         a;
    logic [FAC_W-1:0]         b;
    logic [FAC_W-1:0]         c;
    logic signed [VAL_W-1:0]  p;
    logic signed [VAL_W-1:0]  q;
    logic signed [VAL_W-1:0]  q2;
    logic signed [VAL_W-1:0]  qa;   // q after first pass
    logic signed [VAL_W-1:0]  pa;   // p after first pass
    logic signed [VAL_W-1:0]  qb;   // q2 after second pass
  } cell_t;

  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v > PROD_W'(signed'(32'sh7fffffff)))
      return 32'sh7fffffff;
    else if (v < PROD_W'(signed'(32'sh80000000)))
      return 32'sh80000000;
    else
      return v[VAL_W-1:0];
  endfunction

  // divide by 2^16, rounding half up
  function automatic logic signed [PROD_W-1:0] scale16(input logic signed [PROD_W-1:0] v);
    return (v + PROD_W'(32768)) >>> 16;
  endfunction

endpackage

// ===== hw/rtl/pbc_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module pbc_div
  import pbc_pkg::*;
#(
  parameter int NW = NUM_W,
  parameter int DW = FAC_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [DW-1:0] quo,
  output logic          done
);

  localparam int CW = $clog2(NW + 1);

  logic          run;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [DW-1:0] den_r;
  logic [NW-1:0] nq;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem, nq[NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign quo   = nq[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(NW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      nq    <= num;
      den_r <= den;
    end else if (run) begin
      rem <= ge ? DW'(trial - {1'b0, den_r}) : DW'(trial);
      nq  <= {nq[NW-2:0], ge};
    end
  end

endmodule

// ===== hw/rtl/pml_boundary_cell_update.sv =====
// Top level: factor table, load dividers and eight-stage cell update pipeline.
// Cell items: one item per cycle sustained while the output is not stalled and no load runs.
// Load items: three serial dividers run in parallel, then one table write follows;
// no item is accepted until the write.
// Reset (rst, synchronous) clears pipeline valids, divider control and sets
// layers_in_use to 32; the factor table holds garbage until loaded.
module pml_boundary_cell_update
  import pbc_pkg::*;
#(
  parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [119:0] s_tdata,   // layer[5:0], gain[20:6], p_in, q_in, q2_in, zero pad
  input  logic [3:0]   s_tuser,   // operation[1:0], side[3:2]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // p_out, q_out, q2_out, mirror_p
  output logic         m_tuser,   // mirror_valid
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [6:0]   cfg_data
);

  localparam int AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int EW = 3 * FAC_W;

  // input fields
  logic [1:0]              op;
  logic [1:0]              side;
  logic [5:0]              layer;
  logic [14:0]             gain;
  logic signed [VAL_W-1:0] p_in, q_in, q2_in;

  assign op    = s_tuser[1:0];
  assign side  = s_tuser[3:2];
  assign layer = s_tdata[5:0];
  assign gain  = s_tdata[20:6];
  assign p_in  = s_tdata[52:21];
  assign q_in  = s_tdata[84:53];
  assign q2_in = s_tdata[116:85];

  logic [6:0] layers_in_use;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) layers_in_use <= LAYERS_RST;
    else if (cfg_valid) layers_in_use <= cfg_data;
  end

  // clamped layer count and table index
  logic [CNT_W-1:0] nl, lay, idx;
  always_comb begin
    nl = CNT_W'(layers_in_use);
    if (nl < CNT_W'(2)) nl = CNT_W'(2);
    if (nl > CNT_W'(MAX_LAYERS)) nl = CNT_W'(MAX_LAYERS);
    lay = CNT_W'(layer);
    idx = (side == SIDE_TOP) ? lay : CNT_W'(nl - CNT_W'(1) - lay);
  end

  // pipeline control
  logic adv, accept, cell_go, ld_go, busy;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv && !busy;
  assign accept   = s_tvalid && s_tready;
  assign cell_go  = accept && (op == OP_SINGLE || op == OP_DOUBLE);
  assign ld_go    = accept && (op == OP_LOAD) && (lay < CNT_W'(MAX_LAYERS));

  // factor derivation for loads
  logic [15:0]      dmg, dpg;
  logic [29:0]      gg;
  logic [30:0]      den_b;
  logic [NUM_W-1:0] n_a, n_b, n_c;
  logic [FAC_W-1:0] d_a, d_b, d_c, q_a, q_b, q_c;
  logic             done_a, done_b, done_c;
  logic [AW-1:0]    wr_addr;

  always_comb begin
    dmg   = 16'(17'd32768 - 17'(gain));
    dpg   = 16'(17'd32768 + 17'(gain));
    gg    = 30'(gain) * 30'(gain);
    den_b = 31'(32'h4000_0000 - 32'(gg));
    n_a   = NUM_W'({dmg, 17'b0}) + NUM_W'(dpg);
    d_a   = FAC_W'({dpg, 1'b0});
    n_b   = NUM_W'({gain, 33'b0}) + NUM_W'(den_b);
    d_b   = FAC_W'({den_b, 1'b0});
    n_c   = NUM_W'(33'h1_0000_0000) + NUM_W'(dmg);
    d_c   = FAC_W'({dmg, 1'b0});
  end

  pbc_div u_div_a (.clk, .rst, .start(ld_go), .num(n_a), .den(d_a), .quo(q_a), .done(done_a));
  pbc_div u_div_b (.clk, .rst, .start(ld_go), .num(n_b), .den(d_b), .quo(q_b), .done(done_b));
  pbc_div u_div_c (.clk, .rst, .start(ld_go), .num(n_c), .den(d_c), .quo(q_c), .done(done_c));

  always_ff @(posedge clk) begin
    if (rst) busy <= 1'b0;
    else if (ld_go) busy <= 1'b1;
    else if (done_a) busy <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (ld_go) wr_addr <= lay[AW-1:0];
  end

  // factor table: {C, B, A}
  logic [EW-1:0] table_mem [MAX_LAYERS];
  logic [EW-1:0] rdat;

  always_ff @(posedge clk) begin
    if (done_a && done_b && done_c) table_mem[wr_addr] <= {q_c, q_b, q_a};
  end

  always_ff @(posedge clk) begin
    if (adv) rdat <= table_mem[idx[AW-1:0]];
  end

  // pipeline stages
  cell_t s1, s2, s3, s4, s5, s6, s7;
  cell_t s1_next, s2_next, s3_next, s4_next, s6_next;
  logic  v1, v2, v3, v4, v5, v6, v7;
  logic signed [PROD_W-1:0] m_aq, m_bp, m_cp, sc1, sc2;
  logic signed [PROD_W-1:0] m_aq2, m_bp2, m_cp2;
  logic signed [VAL_W-1:0]  p2, pn;
  logic                     mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, m_tvalid} <= '0;
    end else if (adv) begin
      v1       <= cell_go;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      v5       <= v4;
      v6       <= v5;
      v7       <= v6;
      m_tvalid <= v7;
    end
  end

  always_comb begin
    // stage 1: decode, table read in flight
    s1_next     = '0;
    s1_next.act = lay < nl;
    s1_next.mir = (side == SIDE_BOT_SYM || side == SIDE_BOT_ANTI) && lay == nl - CNT_W'(1);
    s1_next.neg = side == SIDE_BOT_ANTI;
    s1_next.dbl = op == OP_DOUBLE;
    s1_next.p   = p_in;
    s1_next.q   = q_in;
    s1_next.q2  = q2_in;

    // stage 2: factors from the table
    s2_next   = s1;
    s2_next.a = rdat[FAC_W-1:0];
    s2_next.b = rdat[2*FAC_W-1:FAC_W];
    s2_next.c = rdat[EW-1:2*FAC_W];

    // stage 3: scale first pass
    s3_next    = s2;
    s3_next.qa = sat32(scale16(m_aq - m_bp));

    // stage 4: p after first pass
    s4_next    = s3;
    s4_next.pa = sat32(PROD_W'(s3.qa) + sc1);

    // stage 6: scale second pass
    s6_next    = s5;
    s6_next.qb = sat32(scale16(m_aq2 - m_bp2));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1   <= s1_next;

      // stage 2: first-pass products
      s2   <= s2_next;
      m_aq <= PROD_W'(signed'({1'b0, rdat[FAC_W-1:0]})) * PROD_W'(s1.q);
      m_bp <= PROD_W'(signed'({1'b0, rdat[2*FAC_W-1:FAC_W]})) * PROD_W'(s1.p);
      m_cp <= PROD_W'(signed'({1'b0, rdat[EW-1:2*FAC_W]})) * PROD_W'(s1.p);

      s3   <= s3_next;
      sc1  <= scale16(m_cp);

      s4   <= s4_next;

      // stage 5: second-pass products
      s5   <= s4;

      s6   <= s6_next;
      sc2  <= scale16(m_cp2);

      // stage 7: p after second pass
      s7 <= s6;
      p2 <= sat32(PROD_W'(s6.qb) + sc2);

      // stage 8: select and mirror
      m_tdata[31:0]   <= pn;
      m_tdata[63:32]  <= s7.act ? s7.qa : s7.q;
      m_tdata[95:64]  <= (s7.act && s7.dbl) ? s7.qb : s7.q2;
      m_tuser         <= mv;
      m_tdata[127:96] <= !mv ? '0 : (!s7.neg ? pn :
                         (pn == 32'sh80000000 ? 32'sh7fffffff : -pn));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_aq2 <= PROD_W'(signed'({1'b0, s4.a})) * PROD_W'(s4.q2);
      m_bp2 <= PROD_W'(signed'({1'b0, s4.b})) * PROD_W'(s4.pa);
      m_cp2 <= PROD_W'(signed'({1'b0, s4.c})) * PROD_W'(s4.pa);
    end
  end

  assign pn = !s7.act ? s7.p : (s7.dbl ? p2 : s7.pa);
  assign mv = s7.act && s7.mir;

  // checks
  a_busy_blocks: assert property (@(posedge clk) disable iff (rst)
    busy |-> !s_tready) else $error("input taken during table load");

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    ld_go |=> busy) else $error("load did not start divider");

  a_mirror_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[127:96] == '0)) else $error("stray mirror value");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready) else $error("input taken while stalled");

endmodule
